// ===== sv/pts_pkg.sv =====
// ============================================================================
// pts_pkg
// Shared types and constants of the priority thread scheduler.
// ============================================================================
package pts_pkg;

    localparam int MaxThreads = 16;
    localparam int SlotW      = $clog2(MaxThreads);
    localparam int CntW       = $clog2(MaxThreads + 1);

    localparam logic [3:0] OP_INIT  = 4'd0;
    localparam logic [3:0] OP_CREATE = 4'd1;
    localparam logic [3:0] OP_READY = 4'd2;
    localparam logic [3:0] OP_BLOCK = 4'd3;
    localparam logic [3:0] OP_WAKE  = 4'd4;
    localparam logic [3:0] OP_DRAIN = 4'd5;
    localparam logic [3:0] OP_YIELD = 4'd6;
    localparam logic [3:0] OP_EXIT  = 4'd7;
    localparam logic [3:0] OP_QUERY = 4'd8;

    localparam logic [2:0] ST_READY   = 3'd0;
    localparam logic [2:0] ST_RUNNING = 3'd1;
    localparam logic [2:0] ST_BLOCKED = 3'd2;
    localparam logic [2:0] ST_DRAIN   = 3'd3;
    localparam logic [2:0] ST_DEAD    = 3'd4;

    localparam logic [4:0] DEFAULT_PRIO = 5'd16;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_RUNNING  = 2'd2;
    localparam logic [1:0] STAT_DEADLOCK = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [4:0]  prio;
        logic [2:0]  st;
        logic [31:0] key;
    } slot_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DISP,
        S_DRAIN,
        S_DISP2,
        S_FIN,
        S_OUT
    } state_t;

endpackage

// ===== sv/priority_thread_scheduler_core.sv =====
// ============================================================================
// priority_thread_scheduler_core
// Sixteen-slot thread table held in a synchronous memory with one read and one write port.
// The accepted word is handled in passes, each a sweep of the table: the lookup always,
// then an update-and-pick sweep when the operation wakes, preempts or switches the
// running thread, and a drain release sweep when nothing is ready and a slot drains.
// One word at a time; the next word is taken in the cycle after the result leaves.
// Reset: the used bits and the run token clear; slot contents are left as is.
// ============================================================================
module priority_thread_scheduler_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[3:0], thread_id[35:4], priority_req[40:36], wait_key[72:41]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // running_valid[0], running_id[32:1], status[34:33], is_dead[35], is_tracked[36]
    output logic [39:0] m_tdata
);

    localparam int SW = pts_pkg::SlotW;
    localparam int CW = pts_pkg::CntW;

    pts_pkg::slot_t mem [pts_pkg::MaxThreads];
    pts_pkg::slot_t rd;
    logic                we;
    logic [SW-1:0]       waddr;
    pts_pkg::slot_t      wdata;
    logic [SW-1:0]       raddr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd <= (we && waddr == raddr) ? wdata : mem[raddr];
    end

    pts_pkg::state_t state_reg, state_next;
    logic [pts_pkg::MaxThreads-1:0] used_reg, used_next;
    logic [SW-1:0] run_reg, run_next;
    logic          runp_reg, runp_next;
    logic [3:0]    op_reg;
    logic [31:0]   id_reg, key_reg;
    logic [4:0]    prio_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rv_reg, rv_next;
    logic [SW-1:0] ra_reg, ra_next;
    logic          found_reg, found_next;
    logic [SW-1:0] fs_reg, fs_next;
    pts_pkg::slot_t fd_reg, fd_next;
    logic          best_v_reg, best_v_next;
    logic [SW-1:0] best_reg, best_next;
    logic [4:0]    bprio_reg, bprio_next;
    logic          other_rdy_reg, other_rdy_next;
    logic          blk_reg, blk_next;
    logic          drn_reg, drn_next;
    logic [31:0]   cur_id_reg, cur_id_next;
    logic [4:0]    cur_prio_reg, cur_prio_next;
    logic [1:0]    status_reg, status_next;
    logic          dead_reg, dead_next, trk_reg, trk_next;
    logic [31:0]   rid_reg, rid_next;
    logic          ex_reg, ex_next;
    logic          rdy_hit_reg, rdy_hit_next;
    logic [31:0]   fd_key_cur;
    logic [31:0]   cur_key_reg;

    logic [SW-1:0] idx;
    logic          last;
    logic          uv;
    assign idx  = ra_reg;
    assign last = (cnt_reg == CW'(pts_pkg::MaxThreads - 1));
    assign uv   = rv_reg && used_reg[idx];

    assign s_tready = (state_reg == pts_pkg::S_IDLE);
    assign m_tvalid = (state_reg == pts_pkg::S_OUT);
    assign m_tdata  = {3'd0, trk_reg, dead_reg, status_reg, rid_reg, runp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::S_IDLE;
            used_reg  <= '0;
            run_reg   <= '0;
            runp_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            run_reg   <= run_next;
            runp_reg  <= runp_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tdata[3:0];
            id_reg   <= s_tdata[35:4];
            prio_reg <= s_tdata[40:36];
            key_reg  <= s_tdata[72:41];
        end
        cnt_reg       <= cnt_next;
        ra_reg        <= ra_next;
        found_reg     <= found_next;
        fs_reg        <= fs_next;
        fd_reg        <= fd_next;
        best_v_reg    <= best_v_next;
        best_reg      <= best_next;
        bprio_reg     <= bprio_next;
        other_rdy_reg <= other_rdy_next;
        blk_reg       <= blk_next;
        drn_reg       <= drn_next;
        cur_id_reg    <= cur_id_next;
        cur_prio_reg  <= cur_prio_next;
        status_reg    <= status_next;
        dead_reg      <= dead_next;
        trk_reg       <= trk_next;
        rid_reg       <= rid_next;
        ex_reg        <= ex_next;
        rdy_hit_reg   <= rdy_hit_next;
    end

    // Sweep: raddr runs 0..15 for one pass; rd of slot ra_reg is valid when rv_reg.
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        run_next       = run_reg;
        runp_next      = runp_reg;
        rv_next        = 1'b0;
        ra_next        = ra_reg;
        cnt_next       = cnt_reg;
        raddr          = '0;
        we             = 1'b0;
        waddr          = idx;
        wdata          = rd;
        found_next     = found_reg;
        fs_next        = fs_reg;
        fd_next        = fd_reg;
        best_v_next    = best_v_reg;
        best_next      = best_reg;
        bprio_next     = bprio_reg;
        other_rdy_next = other_rdy_reg;
        blk_next       = blk_reg;
        drn_next       = drn_reg;
        cur_id_next    = cur_id_reg;
        cur_prio_next  = cur_prio_reg;
        status_next    = status_reg;
        dead_next      = dead_reg;
        trk_next       = trk_reg;
        rid_next       = rid_reg;
        ex_next        = ex_reg;
        rdy_hit_next   = rdy_hit_reg;
        unique case (state_reg) inside
            pts_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next     = pts_pkg::S_SCAN;
                    raddr          = '0;
                    ra_next        = '0;
                    rv_next        = 1'b1;
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    other_rdy_next = 1'b0;
                    status_next    = pts_pkg::STAT_OK;
                    dead_next      = 1'b0;
                    trk_next       = 1'b0;
                    ex_next        = 1'b0;
                    rdy_hit_next   = 1'b0;
                end
            end
            // Lookup pass: lowest matching id, any other ready slot, running slot data.
            pts_pkg::S_SCAN:
            begin
                if (uv && !found_reg && rd.id == id_reg)
                begin
                    found_next = 1'b1;
                    fs_next    = idx;
                    fd_next    = rd;
                end
                if (uv && rd.st == pts_pkg::ST_READY)
                begin
                    other_rdy_next = 1'b1;
                end
                if (rv_reg && idx == run_reg)
                begin
                    cur_id_next   = rd.id;
                    cur_prio_next = rd.prio;
                end
                if (last)
                begin
                    state_next = pts_pkg::S_APPLY;
                    ra_next    = '0;
                    cnt_next   = '0;
                    raddr      = '0;
                    rv_next    = 1'b1;
                end
                else
                begin
                    raddr    = SW'(cnt_reg + 1'b1);
                    ra_next  = raddr;
                    cnt_next = cnt_reg + 1'b1;
                    rv_next  = 1'b1;
                end
            end
            pts_pkg::S_APPLY:
            begin
                state_next = pts_pkg::S_FIN;
                case (op_reg) inside
                    pts_pkg::OP_INIT:
                    begin
                        used_next = '0;
                        used_next[0] = 1'b1;
                        we    = 1'b1;
                        waddr = '0;
                        wdata = '{id: id_reg, prio: pts_pkg::DEFAULT_PRIO,
                                  st: pts_pkg::ST_RUNNING, key: 32'd0};
                        run_next  = '0;
                        runp_next = 1'b1;
                    end
                    pts_pkg::OP_CREATE:
                    begin
                        if (found_reg && fd_reg.st == pts_pkg::ST_RUNNING)
                        begin
                            status_next = pts_pkg::STAT_RUNNING;
                        end
                        else if (found_reg)
                        begin
                            we    = 1'b1;
                            waddr = fs_reg;
                            wdata = '{id: fd_reg.id, prio: prio_reg,
                                      st: pts_pkg::ST_BLOCKED, key: 32'd0};
                        end
                        else if (&used_reg)
                        begin
                            status_next = pts_pkg::STAT_FULL;
                        end
                        else
                        begin
                            for (int i = pts_pkg::MaxThreads - 1; i >= 0; i--)
                            begin
                                if (!used_reg[i])
                                begin
                                    waddr = SW'(i);
                                end
                            end
                            we    = 1'b1;
                            used_next[waddr] = 1'b1;
                            wdata = '{id: id_reg, prio: prio_reg,
                                      st: pts_pkg::ST_BLOCKED, key: 32'd0};
                        end
                    end
                    pts_pkg::OP_READY:
                    begin
                        if (found_reg && fd_reg.st != pts_pkg::ST_DEAD &&
                            fd_reg.st != pts_pkg::ST_RUNNING)
                        begin
                            we    = 1'b1;
                            waddr = fs_reg;
                            wdata = '{id: fd_reg.id, prio: fd_reg.prio,
                                      st: pts_pkg::ST_READY, key: 32'd0};
                            rdy_hit_next = 1'b1;
                            if (runp_reg && fd_reg.prio < cur_prio_reg)
                            begin
                                state_next = pts_pkg::S_DISP;
                            end
                        end
                    end
                    pts_pkg::OP_BLOCK, pts_pkg::OP_DRAIN, pts_pkg::OP_YIELD,
                    pts_pkg::OP_EXIT:
                    begin
                        if (runp_reg && (other_rdy_reg ||
                            op_reg == pts_pkg::OP_BLOCK || op_reg == pts_pkg::OP_EXIT))
                        begin
                            state_next = pts_pkg::S_DISP;
                            ex_next    = (op_reg == pts_pkg::OP_EXIT);
                            we    = 1'b1;
                            waddr = run_reg;
                            wdata = '{id: cur_id_reg, prio: cur_prio_reg,
                                      st: pts_pkg::ST_READY, key: 32'd0};
                            case (op_reg)
                                pts_pkg::OP_BLOCK:
                                begin
                                    wdata.st  = pts_pkg::ST_BLOCKED;
                                    wdata.key = key_reg;
                                end
                                pts_pkg::OP_DRAIN: wdata.st = pts_pkg::ST_DRAIN;
                                pts_pkg::OP_EXIT:  wdata.st = pts_pkg::ST_DEAD;
                                default: wdata.st = pts_pkg::ST_READY;
                            endcase
                            // Keep key of the slot for yield/drain/exit: rewritten below.
                            if (op_reg != pts_pkg::OP_BLOCK)
                            begin
                                wdata.key = fd_key_cur;
                            end
                        end
                    end
                    pts_pkg::OP_WAKE:
                    begin
                        state_next = pts_pkg::S_DISP;
                    end
                    pts_pkg::OP_QUERY:
                    begin
                        trk_next  = found_reg;
                        dead_next = !found_reg || fd_reg.st == pts_pkg::ST_DEAD;
                    end
                    default: ;
                endcase
                // Preempt on make-ready: old running slot becomes ready.
                if (op_reg == pts_pkg::OP_READY && state_next == pts_pkg::S_DISP)
                begin
                    ex_next = 1'b0;
                end
                raddr    = '0;
                ra_next  = '0;
                cnt_next = '0;
                rv_next  = (state_next == pts_pkg::S_DISP);
                best_v_next = 1'b0;
                blk_next    = 1'b0;
                drn_next    = 1'b0;
            end
            // Update-and-pick pass. Writes land on the slot just read.
            pts_pkg::S_DISP, pts_pkg::S_DISP2, pts_pkg::S_DRAIN:
            begin
                if (uv)
                begin
                    wdata = rd;
                    if (state_reg == pts_pkg::S_DISP)
                    begin
                        if (op_reg == pts_pkg::OP_READY && idx == run_reg && runp_reg)
                        begin
                            wdata.st = pts_pkg::ST_READY;
                            we = 1'b1;
                        end
                        if ((op_reg == pts_pkg::OP_WAKE || ex_reg) &&
                            rd.st == pts_pkg::ST_BLOCKED &&
                            rd.key == (ex_reg ? cur_id_reg : key_reg))
                        begin
                            wdata.st  = pts_pkg::ST_READY;
                            wdata.key = 32'd0;
                            we = 1'b1;
                        end
                    end
                    if (state_reg == pts_pkg::S_DRAIN && rd.st == pts_pkg::ST_DRAIN)
                    begin
                        wdata.st = pts_pkg::ST_READY;
                        we = 1'b1;
                    end
                    if (wdata.st == pts_pkg::ST_READY &&
                        (!best_v_reg || wdata.prio < bprio_reg))
                    begin
                        best_v_next = 1'b1;
                        best_next   = idx;
                        bprio_next  = wdata.prio;
                    end
                    if (wdata.st == pts_pkg::ST_BLOCKED)
                    begin
                        blk_next = 1'b1;
                    end
                    if (wdata.st == pts_pkg::ST_DRAIN)
                    begin
                        drn_next = 1'b1;
                    end
                end
                if (last)
                begin
                    state_next = pts_pkg::S_FIN;
                    if (op_reg == pts_pkg::OP_WAKE)
                    begin
                        state_next = pts_pkg::S_FIN;
                    end
                    else if (best_v_next)
                    begin
                        state_next = pts_pkg::S_FIN;
                        ex_next    = 1'b1;
                    end
                    else if (state_reg == pts_pkg::S_DISP && drn_next)
                    begin
                        state_next  = pts_pkg::S_DRAIN;
                        ra_next     = '0;
                        cnt_next    = '0;
                        raddr       = '0;
                        rv_next     = 1'b1;
                        blk_next    = 1'b0;
                        drn_next    = 1'b0;
                        best_v_next = 1'b0;
                    end
                    else
                    begin
                        runp_next   = 1'b0;
                        run_next    = '0;
                        status_next = blk_next ? pts_pkg::STAT_DEADLOCK
                                               : pts_pkg::STAT_OK;
                        ex_next     = 1'b0;
                    end
                end
                else
                begin
                    raddr    = SW'(cnt_reg + 1'b1);
                    ra_next  = raddr;
                    cnt_next = cnt_reg + 1'b1;
                    rv_next  = 1'b1;
                end
            end
            // Install the picked slot as running and fetch the running id.
            pts_pkg::S_FIN:
            begin
                if (ex_reg && op_reg != pts_pkg::OP_INIT && op_reg != pts_pkg::OP_QUERY &&
                    op_reg != pts_pkg::OP_CREATE && op_reg != pts_pkg::OP_WAKE &&
                    best_v_reg && !rv_reg)
                begin
                    run_next  = best_reg;
                    runp_next = 1'b1;
                    raddr     = best_reg;
                    ra_next   = best_reg;
                    rv_next   = 1'b1;
                    ex_next   = 1'b0;
                end
                else if (!rv_reg)
                begin
                    raddr   = run_reg;
                    ra_next = run_reg;
                    rv_next = 1'b1;
                end
                else
                begin
                    if (idx == run_reg && best_v_reg && rd.st == pts_pkg::ST_READY &&
                        runp_reg && op_reg != pts_pkg::OP_WAKE && op_reg != pts_pkg::OP_QUERY)
                    begin
                        we = 1'b1;
                        wdata = rd;
                        wdata.st = pts_pkg::ST_RUNNING;
                    end
                    rid_next   = runp_reg ? rd.id : 32'd0;
                    state_next = pts_pkg::S_OUT;
                end
            end
            pts_pkg::S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = pts_pkg::S_IDLE;
                end
            end
            default: state_next = pts_pkg::S_IDLE;
        endcase
    end

    // Running slot's own wait key, kept when yield, drain or exit rewrite it.
    always_ff @(posedge clk)
    begin
        if (state_reg == pts_pkg::S_SCAN && rv_reg && idx == run_reg)
        begin
            cur_key_reg <= rd.key;
        end
    end
    assign fd_key_cur = cur_key_reg;

endmodule
